// ===== hw/rtl/mpq_pkg.sv =====
// Package for the max priority queue: the item and result beat types, the
// status and action codes, and the per-cell command struct.
// No dependencies.
`default_nettype none

package mpq_pkg;

	localparam int MPQ_DEPTH = 16;
	localparam int VALUE_W   = 32;

	localparam logic ACT_INSERT = 1'b0;
	localparam logic ACT_REMOVE = 1'b1;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	typedef struct packed {
		logic                      action;
		logic signed [VALUE_W-1:0] value;
	} mpq_item_t;

	typedef struct packed {
		logic signed [VALUE_W-1:0] removed_value;
		logic [1:0]                status;
		logic [4:0]                occupancy;
	} mpq_result_t;

	// Broadcast to every cell in the chain for one beat
	typedef struct packed {
		logic                      ins;
		logic                      rem;
		logic signed [VALUE_W-1:0] value;
	} mpq_cell_cmd_t;

endpackage

`default_nettype wire

// ===== hw/rtl/max_priority_queue_core.sv =====
// Top level of the max priority queue: a chain of sorted cells and the
// fill counter. Depends on mpq_pkg and mpq_cell.
//
// Takes one beat per clock: busy is held low, and every beat accepted on
// start gives its result in the next cycle with done high for that single
// cycle; the receiver cannot stall it. The values sit in a chain of
// QUEUE_DEPTH cells kept in descending order, one comparator per cell, so
// the largest is always at the head. An insert lands in its sorted place and
// pushes the smaller values down one cell in the same cycle; a remove takes
// the head and moves every cell up one place. No clearing pass after reset.
`default_nettype none

module max_priority_queue_core #(
	parameter int QUEUE_DEPTH = mpq_pkg::MPQ_DEPTH
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	output logic                      busy,
	input  wire mpq_pkg::mpq_item_t   item,
	output logic                      done,
	output mpq_pkg::mpq_result_t      result
);
	import mpq_pkg::*;

	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	logic [CW-1:0]             count_q;
	logic [CW-1:0]             count_nxt;
	logic                      accept;
	logic                      full;
	logic                      empty;
	mpq_cell_cmd_t             cmd;
	logic signed [VALUE_W-1:0] vals [QUEUE_DEPTH];
	logic                      gts  [QUEUE_DEPTH];
	logic                      done_q;
	mpq_result_t               result_q;
	logic [31:0]               occ_ext;

	assign busy   = 1'b0;
	assign accept = start && !busy;
	assign full   = (count_q == CW'(QUEUE_DEPTH));
	assign empty  = (count_q == '0);

	assign cmd.ins   = accept && (item.action == ACT_INSERT) && !full;
	assign cmd.rem   = accept && (item.action == ACT_REMOVE) && !empty;
	assign cmd.value = item.value;

	always_comb begin
		count_nxt = count_q;
		if (cmd.ins) begin
			count_nxt = count_q + CW'(1);
		end else if (cmd.rem) begin
			count_nxt = count_q - CW'(1);
		end
	end

	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		logic signed [VALUE_W-1:0] prev_val;
		logic                      prev_gt;
		logic signed [VALUE_W-1:0] next_val;

		if (i == 0) begin : g_head
			assign prev_val = item.value;
			assign prev_gt  = 1'b0;
		end else begin : g_body
			assign prev_val = vals[i-1];
			assign prev_gt  = gts[i-1];
		end

		if (i == QUEUE_DEPTH - 1) begin : g_tail
			assign next_val = vals[i];
		end else begin : g_mid
			assign next_val = vals[i+1];
		end

		mpq_cell #(
			.IDX (i),
			.CW  (CW)
		) u_cell (
			.clk      (clk),
			.cmd      (cmd),
			.count    (count_q),
			.prev_val (prev_val),
			.prev_gt  (prev_gt),
			.next_val (next_val),
			.val      (vals[i]),
			.gt       (gts[i])
		);
	end

	assign occ_ext = 32'(count_nxt);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			count_q <= count_nxt;
			done_q  <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			result_q.removed_value <= cmd.rem ? vals[0] : '0;
			result_q.occupancy     <= occ_ext[4:0];
			priority if (item.action == ACT_INSERT && full) begin
				result_q.status <= ST_FULL;
			end else if (item.action == ACT_REMOVE && empty) begin
				result_q.status <= ST_EMPTY;
			end else begin
				result_q.status <= ST_OK;
			end
		end
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

`default_nettype wire

// ===== hw/rtl/mpq_cell.sv =====
// One cell of the sorted chain: holds one value, kept in descending order
// along the chain. Depends on mpq_pkg.
`default_nettype none

module mpq_cell #(
	parameter int IDX = 0,
	parameter int CW  = 5
) (
	input  wire logic                              clk,
	input  wire mpq_pkg::mpq_cell_cmd_t            cmd,
	input  wire logic [CW-1:0]                     count,
	input  wire logic signed [mpq_pkg::VALUE_W-1:0] prev_val,
	input  wire logic                              prev_gt,
	input  wire logic signed [mpq_pkg::VALUE_W-1:0] next_val,
	output logic signed [mpq_pkg::VALUE_W-1:0]      val,
	output logic                                   gt
);
	import mpq_pkg::*;

	logic signed [VALUE_W-1:0] val_q;
	logic                      empty_slot;

	// A slot at or past the fill level counts as lower than anything
	assign empty_slot = (CW'(IDX) >= count);
	assign gt         = empty_slot || (cmd.value > val_q);
	assign val        = val_q;

	always_ff @(posedge clk) begin
		if (cmd.ins) begin
			if (prev_gt) begin
				val_q <= prev_val;  // shift down behind the new value
			end else if (gt) begin
				val_q <= cmd.value;
			end
		end else if (cmd.rem) begin
			val_q <= next_val;      // advance towards the head
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/mpq_chk.sv =====
// Port-level checker for the max priority queue, bound to the top level.
// Depends on mpq_pkg and max_priority_queue_core.
`default_nettype none

module mpq_chk #(
	parameter int DEPTH = mpq_pkg::MPQ_DEPTH
) (
	input wire logic                 clk,
	input wire logic                 arst_n,
	input wire logic                 start,
	input wire logic                 busy,
	input wire logic                 done,
	input wire mpq_pkg::mpq_result_t result
);
	import mpq_pkg::*;

	localparam logic [31:0] DEPTH_W = 32'(DEPTH);
	localparam logic [4:0]  DEPTH_OCC = DEPTH_W[4:0];

	// Every accepted beat gives a result in the next cycle
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> done)
		else $error("accepted beat gave no result");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy))
		else $error("result without an accepted beat");

	a_empty_result: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.status == ST_EMPTY) |->
		(result.removed_value == '0 && result.occupancy == '0))
		else $error("empty remove carried data or occupancy");

	a_full_result: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.status == ST_FULL) |->
		(result.removed_value == '0 && result.occupancy == DEPTH_OCC))
		else $error("dropped insert with wrong occupancy");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (result.status == ST_OK || result.status == ST_EMPTY ||
		result.status == ST_FULL))
		else $error("undefined status code");

endmodule

bind max_priority_queue_core mpq_chk #(.DEPTH(QUEUE_DEPTH)) u_mpq_chk (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.result (result)
);

`default_nettype wire
